[rtl/gqv_pkg.sv]
// ----------------------------------------------------------------------------
// gqv_pkg
// Types, constants and helper functions shared by the glyph quad vertex
// generator modules.
// ----------------------------------------------------------------------------
package gqv_pkg;

    localparam logic [7:0]  NEWLINE_CODE  = 8'd10;
    localparam logic [15:0] STEP_FRACTION = 16'd39322;
    localparam logic [27:0] STEP_ROUND    = 28'd32768;

    localparam logic [1:0] REG_ORIGIN_X   = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y   = 2'd1;
    localparam logic [1:0] REG_GLYPH_SIZE = 2'd2;
    localparam logic [1:0] REG_COLOR_RGBA = 2'd3;

    localparam logic [11:0] GLYPH_SIZE_RESET = 12'd256;
    localparam logic [31:0] COLOR_RESET      = 32'hFFFF_FFFF;

    typedef logic [2:0] vtx_idx_t;

    localparam vtx_idx_t VTX_TL_A = 3'd0;
    localparam vtx_idx_t VTX_TR_A = 3'd1;
    localparam vtx_idx_t VTX_BL_A = 3'd2;
    localparam vtx_idx_t VTX_BL_B = 3'd3;
    localparam vtx_idx_t VTX_TR_B = 3'd4;
    localparam vtx_idx_t VTX_BR_A = 3'd5;

    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [11:0]        glyph_size;
        logic [11:0]        step;
        logic [31:0]        color;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic [3:0]         u;
        logic [3:0]         v;
        logic [31:0]        color;
    } glyph_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    // Adds an unsigned 12-bit offset to a signed position, clamped to 16 bits.
    function automatic logic signed [15:0] sat_add(input logic signed [15:0] base,
                                                   input logic [11:0] offset);
        logic signed [16:0] sum;
        begin
            sum = {base[15], base} + {5'd0, offset};
            if (sum[16] != sum[15])
            begin
                sat_add = sum[16] ? 16'sh8000 : 16'sh7FFF;
            end
            else
            begin
                sat_add = sum[15:0];
            end
        end
    endfunction

    // Cursor advance: glyph size times 0.6, rounded half up.
    function automatic logic [11:0] glyph_step(input logic [11:0] size);
        logic [27:0] prod;
        begin
            prod = ({16'd0, size} * {12'd0, STEP_FRACTION}) + STEP_ROUND;
            glyph_step = prod[27:16];
        end
    endfunction

endpackage

[rtl/gqv_char_if.sv]
// ----------------------------------------------------------------------------
// gqv_char_if
// Character channel: one character byte and its start-of-string flag.
// ----------------------------------------------------------------------------
interface gqv_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       first_of_string;

    modport source (output valid, output char_code, output first_of_string, input ready);
    modport sink (input valid, input char_code, input first_of_string, output ready);
endinterface

[rtl/gqv_vertex_if.sv]
// ----------------------------------------------------------------------------
// gqv_vertex_if
// Vertex channel: one textured, coloured vertex of a glyph quad.
// ----------------------------------------------------------------------------
interface gqv_vertex_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [4:0]         tex_u;
    logic [4:0]         tex_v;
    logic [31:0]        vertex_color;
    logic               last_vertex;

    modport source (output valid, output pos_x, output pos_y, output tex_u, output tex_v,
                    output vertex_color, output last_vertex, input ready);
    modport sink (input valid, input pos_x, input pos_y, input tex_u, input tex_v,
                  input vertex_color, input last_vertex, output ready);
endinterface

[rtl/gqv_front.sv]
// ----------------------------------------------------------------------------
// gqv_front
// Accepts characters, keeps the text cursor and queues one quad per
// non-newline character; newlines only move the cursor.
// ----------------------------------------------------------------------------
module gqv_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    gqv_char_if.sink              chars,
    input  gqv_pkg::cfg_t         cfg,
    input  gqv_pkg::fifo_status_t fifo_status,
    output logic                  push,
    output gqv_pkg::glyph_t       glyph
);

    logic signed [15:0] cursor_x_reg;
    logic signed [15:0] cursor_x_next;
    logic signed [15:0] cursor_y_reg;
    logic signed [15:0] cursor_y_next;
    logic signed [15:0] base_x;
    logic signed [15:0] base_y;
    logic               accept;
    logic               is_newline;

    assign chars.ready = !fifo_status.full;
    assign accept      = chars.valid && chars.ready;
    assign is_newline  = (chars.char_code == gqv_pkg::NEWLINE_CODE);

    always_comb
    begin
        base_x = chars.first_of_string ? cfg.origin_x : cursor_x_reg;
        base_y = chars.first_of_string ? cfg.origin_y : cursor_y_reg;

        glyph.x0    = base_x;
        glyph.y0    = base_y;
        glyph.x1    = gqv_pkg::sat_add(base_x, cfg.glyph_size);
        glyph.y1    = gqv_pkg::sat_add(base_y, cfg.glyph_size);
        glyph.u     = chars.char_code[3:0];
        glyph.v     = chars.char_code[7:4];
        glyph.color = cfg.color;

        push          = accept && !is_newline;
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        if (accept)
        begin
            if (is_newline)
            begin
                cursor_x_next = cfg.origin_x;
                cursor_y_next = gqv_pkg::sat_add(base_y, cfg.glyph_size);
            end
            else
            begin
                cursor_x_next = gqv_pkg::sat_add(base_x, cfg.step);
                cursor_y_next = base_y;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
        end
        else
        begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
        end
    end

endmodule

[rtl/gqv_fifo.sv]
// ----------------------------------------------------------------------------
// gqv_fifo
// Short queue of glyph quads between the cursor front end and the vertex
// back end.
// ----------------------------------------------------------------------------
module gqv_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  gqv_pkg::glyph_t       wdata,
    input  logic                  pop,
    output gqv_pkg::glyph_t       rdata,
    output gqv_pkg::fifo_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    gqv_pkg::glyph_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign rdata        = mem[rd_ptr_reg];
    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/gqv_back.sv]
// ----------------------------------------------------------------------------
// gqv_back
// Takes queued glyph quads and sends their six vertices, one per cycle
// while the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module gqv_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  gqv_pkg::glyph_t       glyph,
    input  gqv_pkg::fifo_status_t fifo_status,
    output logic                  pop,
    gqv_vertex_if.source          vertices
);

    gqv_pkg::glyph_t    entry_reg;
    gqv_pkg::glyph_t    entry_next;
    logic               active_reg;
    logic               active_next;
    gqv_pkg::vtx_idx_t  idx_reg;
    gqv_pkg::vtx_idx_t  idx_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [15:0] pos_x_reg;
    logic signed [15:0] pos_y_reg;
    logic [4:0]         tex_u_reg;
    logic [4:0]         tex_v_reg;
    logic [31:0]        color_reg;
    logic               last_reg;
    logic signed [15:0] sel_x;
    logic signed [15:0] sel_y;
    logic               sel_right;
    logic               sel_bottom;
    logic               sel_last;
    logic               load_ok;
    logic               emit;
    logic               done;

    assign load_ok = !out_valid_reg || vertices.ready;
    assign emit    = active_reg && load_ok;
    assign done    = emit && (idx_reg == gqv_pkg::VTX_BR_A);
    assign pop     = !fifo_status.empty && (!active_reg || done);

    always_comb
    begin
        sel_right  = 1'b0;
        sel_bottom = 1'b0;
        sel_last   = 1'b0;
        unique case (idx_reg)
            gqv_pkg::VTX_TL_A:
            begin
                sel_right  = 1'b0;
                sel_bottom = 1'b0;
            end
            gqv_pkg::VTX_TR_A, gqv_pkg::VTX_TR_B:
            begin
                sel_right  = 1'b1;
                sel_bottom = 1'b0;
            end
            gqv_pkg::VTX_BL_A, gqv_pkg::VTX_BL_B:
            begin
                sel_right  = 1'b0;
                sel_bottom = 1'b1;
            end
            gqv_pkg::VTX_BR_A:
            begin
                sel_right  = 1'b1;
                sel_bottom = 1'b1;
                sel_last   = 1'b1;
            end
            default:
            begin
                sel_right  = 1'b0;
                sel_bottom = 1'b0;
            end
        endcase
        sel_x = sel_right  ? entry_reg.x1 : entry_reg.x0;
        sel_y = sel_bottom ? entry_reg.y1 : entry_reg.y0;
    end

    always_comb
    begin
        entry_next  = pop ? glyph : entry_reg;
        active_next = active_reg;
        idx_next    = idx_reg;
        if (pop)
        begin
            active_next = 1'b1;
            idx_next    = gqv_pkg::VTX_TL_A;
        end
        else if (done)
        begin
            active_next = 1'b0;
        end
        else if (emit)
        begin
            idx_next = idx_reg + 1'b1;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (vertices.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (emit)
        begin
            pos_x_reg <= sel_x;
            pos_y_reg <= sel_y;
            tex_u_reg <= {1'b0, entry_reg.u} + {4'd0, sel_right};
            tex_v_reg <= {1'b0, entry_reg.v} + {4'd0, sel_bottom};
            color_reg <= entry_reg.color;
            last_reg  <= sel_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= gqv_pkg::VTX_TL_A;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign vertices.valid        = out_valid_reg;
    assign vertices.pos_x        = pos_x_reg;
    assign vertices.pos_y        = pos_y_reg;
    assign vertices.tex_u        = tex_u_reg;
    assign vertices.tex_v        = tex_v_reg;
    assign vertices.vertex_color = color_reg;
    assign vertices.last_vertex  = last_reg;

endmodule

[rtl/glyph_quad_vertex_generator_top.sv]
// ----------------------------------------------------------------------------
// glyph_quad_vertex_generator_top
// Turns a stream of character bytes into textured quad vertices for a
// 16x16 bitmap font atlas.
// ----------------------------------------------------------------------------
// Characters arrive on the chars channel and vertices leave on the vertices
// channel; each is a valid/ready transaction. The user must write the
// registers (origin, glyph size, colour) through cfg_wr_en, cfg_index and
// cfg_data only while the block is idle; the block does not enforce this.
// A non-newline character yields six vertices, two triangles of one quad,
// the last flagged by last_vertex. A newline is taken and yields nothing
// but a cursor move.
// The quad of a character passes through the queue and the back end's
// entry register before its vertices are loaded into the registered output
// stage; the six vertices then follow at one per cycle while the receiver
// is ready.
// The cursor front end keeps taking characters while vertices wait, until
// its queue of QUEUE_DEPTH quads is full.
// When the receiver stalls, the current vertex holds and the queue fills.
// Reset clears the cursor to zero, the queue and the output stage, and loads
// the register defaults.
// ----------------------------------------------------------------------------
module glyph_quad_vertex_generator_top
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    gqv_char_if.sink     chars,
    gqv_vertex_if.source vertices,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    gqv_pkg::cfg_t         cfg_reg;
    gqv_pkg::glyph_t       push_glyph;
    gqv_pkg::glyph_t       pop_glyph;
    gqv_pkg::fifo_status_t fifo_status;
    logic                  push;
    logic                  pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x   <= '0;
            cfg_reg.origin_y   <= '0;
            cfg_reg.glyph_size <= gqv_pkg::GLYPH_SIZE_RESET;
            cfg_reg.step       <= gqv_pkg::glyph_step(gqv_pkg::GLYPH_SIZE_RESET);
            cfg_reg.color      <= gqv_pkg::COLOR_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                gqv_pkg::REG_ORIGIN_X:
                begin
                    cfg_reg.origin_x <= cfg_data[15:0];
                end
                gqv_pkg::REG_ORIGIN_Y:
                begin
                    cfg_reg.origin_y <= cfg_data[15:0];
                end
                gqv_pkg::REG_GLYPH_SIZE:
                begin
                    cfg_reg.glyph_size <= cfg_data[11:0];
                    cfg_reg.step       <= gqv_pkg::glyph_step(cfg_data[11:0]);
                end
                gqv_pkg::REG_COLOR_RGBA:
                begin
                    cfg_reg.color <= cfg_data;
                end
                default:
                begin
                    cfg_reg.color <= cfg_reg.color;
                end
            endcase
        end
    end

    gqv_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .chars       (chars),
        .cfg         (cfg_reg),
        .fifo_status (fifo_status),
        .push        (push),
        .glyph       (push_glyph)
    );

    gqv_fifo
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  (push_glyph),
        .pop    (pop),
        .rdata  (pop_glyph),
        .status (fifo_status)
    );

    gqv_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .glyph       (pop_glyph),
        .fifo_status (fifo_status),
        .pop         (pop),
        .vertices    (vertices)
    );

`ifndef SYNTH
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !fifo_status.full)
        else $error("quad queued while queue full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !fifo_status.empty)
        else $error("quad taken from empty queue");

    a_newline_no_quad: assert property (@(posedge clk) disable iff (!rst_n)
        (chars.valid && chars.ready && (chars.char_code == gqv_pkg::NEWLINE_CODE))
        |-> !push)
        else $error("newline produced a quad");

    a_vertex_after_quad: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !vertices.valid) |=> ##1 vertices.valid)
        else $error("queued quad did not reach the output");
`endif

endmodule

[dv/glyph_quad_vertex_generator_top_test.sv]
// ----------------------------------------------------------------------------
// glyph_quad_vertex_generator_top_test
// Self-checking testbench for the glyph quad vertex generator. A directed
// table covers reset defaults, atlas corners, newlines, origin loads,
// saturation at both ends of the position range and a zero glyph size. A
// random part follows, made of strings under several register settings. An
// internal cursor model predicts every vertex, and each vertex transaction
// is compared field by field with the oldest prediction. Both channels
// idle in random bursts until the last random phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glyph_quad_vertex_generator_top_test;

    localparam int DIRECTED_ROWS   = 36;
    localparam int RANDOM_PHASES   = 5;
    localparam int ITEMS_PER_PHASE = 17;
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 200000;

    typedef enum logic [1:0]
    {
        ROW_CHAR,
        ROW_CHAR_TYPED,
        ROW_REG
    } row_kind_t;

    typedef struct packed
    {
        row_kind_t   kind;
        logic [1:0]  reg_index;
        logic [31:0] reg_value;
        logic [7:0]  code;
        logic        first;
        logic [15:0] tl_x;
        logic [15:0] tl_y;
        logic [4:0]  tl_u;
        logic [4:0]  tl_v;
    } stim_row_t;

    typedef struct packed
    {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [4:0]  tex_u;
        logic [4:0]  tex_v;
        logic [31:0] vertex_color;
        logic        last_vertex;
    } quad_vertex_t;

    typedef quad_vertex_t glyph_quad_t [6];

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    gqv_char_if   chars_bus ();
    gqv_vertex_if vertex_bus ();

    glyph_quad_vertex_generator_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars_bus),
        .vertices  (vertex_bus),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic signed [15:0] model_origin_x;
    logic signed [15:0] model_origin_y;
    logic [11:0]        model_size;
    logic [31:0]        model_color;
    logic signed [15:0] cursor_x;
    logic signed [15:0] cursor_y;

    quad_vertex_t pending_vertices [$];
    stim_row_t    directed_rows [DIRECTED_ROWS];

    bit idle_enabled = 1'b1;
    int stall_left   = 0;
    int cycle_count  = 0;
    int error_count  = 0;
    int glyph_count  = 0;
    int newline_count = 0;
    int vertex_count = 0;
    int reg_writes   = 0;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic stim_row_t char_row(input logic [7:0] code, input logic first);
        stim_row_t row;
        row       = '0;
        row.kind  = ROW_CHAR;
        row.code  = code;
        row.first = first;
        return row;
    endfunction

    function automatic stim_row_t typed_row(input logic [7:0] code, input logic first,
                                            input int x, input int y, input int u, input int v);
        stim_row_t row;
        row      = char_row(code, first);
        row.kind = ROW_CHAR_TYPED;
        row.tl_x = x[15:0];
        row.tl_y = y[15:0];
        row.tl_u = u[4:0];
        row.tl_v = v[4:0];
        return row;
    endfunction

    function automatic stim_row_t reg_row(input logic [1:0] index, input logic [31:0] value);
        stim_row_t row;
        row           = '0;
        row.kind      = ROW_REG;
        row.reg_index = index;
        row.reg_value = value;
        return row;
    endfunction

    function automatic logic signed [15:0] clamp_add(input int base, input int offset);
        int total;
        total = base + offset;
        if (total > 32767)
            return 16'sh7FFF;
        if (total < -32768)
            return 16'sh8000;
        return total[15:0];
    endfunction

    function automatic logic [31:0] random_position();
        int mode;
        mode = $urandom_range(0, 3);
        if (mode == 0)
            return 32'(32767 - $urandom_range(0, 300));
        if (mode == 1)
            return 32'(-32768 + $urandom_range(0, 300));
        return $urandom;
    endfunction

    task automatic predict_char(input logic [7:0] code, input logic first,
                                output glyph_quad_t quad, output bit emits);
        int                 size;
        int                 step;
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic [4:0]         u;
        logic [4:0]         v;
        size = int'(model_size);
        if (first)
        begin
            cursor_x = model_origin_x;
            cursor_y = model_origin_y;
        end
        if (code == gqv_pkg::NEWLINE_CODE)
        begin
            cursor_x = model_origin_x;
            cursor_y = clamp_add(cursor_y, size);
            emits    = 1'b0;
            newline_count++;
        end
        else
        begin
            u  = {1'b0, code[3:0]};
            v  = {1'b0, code[7:4]};
            x0 = cursor_x;
            y0 = cursor_y;
            x1 = clamp_add(x0, size);
            y1 = clamp_add(y0, size);
            quad[0] = '{x0, y0, u,        v,        model_color, 1'b0};
            quad[1] = '{x1, y0, u + 5'd1, v,        model_color, 1'b0};
            quad[2] = '{x0, y1, u,        v + 5'd1, model_color, 1'b0};
            quad[3] = '{x0, y1, u,        v + 5'd1, model_color, 1'b0};
            quad[4] = '{x1, y0, u + 5'd1, v,        model_color, 1'b0};
            quad[5] = '{x1, y1, u + 5'd1, v + 5'd1, model_color, 1'b1};
            step     = (size * int'(gqv_pkg::STEP_FRACTION) + 32768) >>> 16;
            cursor_x = clamp_add(cursor_x, step);
            emits    = 1'b1;
            glyph_count++;
        end
    endtask

    task automatic wait_for_vertices(input int settle);
        chars_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_vertices.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        wait_for_vertices(SETTLE_CYCLES);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (index)
            gqv_pkg::REG_ORIGIN_X:   model_origin_x = value[15:0];
            gqv_pkg::REG_ORIGIN_Y:   model_origin_y = value[15:0];
            gqv_pkg::REG_GLYPH_SIZE: model_size     = value[11:0];
            gqv_pkg::REG_COLOR_RGBA: model_color    = value;
            default:                 ;
        endcase
        reg_writes++;
    endtask

    task automatic send_char(input stim_row_t row);
        glyph_quad_t quad;
        bit          emits;
        int          gap;
        predict_char(row.code, row.first, quad, emits);
        if (emits)
        begin
            if (row.kind == ROW_CHAR_TYPED)
            begin
                quad[0].pos_x = row.tl_x;
                quad[0].pos_y = row.tl_y;
                quad[0].tex_u = row.tl_u;
                quad[0].tex_v = row.tl_v;
            end
            for (int k = 0; k < 6; k++)
                pending_vertices = {pending_vertices, quad[k]};
        end
        if (idle_enabled && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 5);
            chars_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chars_bus.valid           <= 1'b1;
        chars_bus.char_code       <= row.code;
        chars_bus.first_of_string <= row.first;
        do
            @(posedge clk);
        while (!chars_bus.ready);
    endtask

    task automatic check_vertex();
        quad_vertex_t want;
        if (pending_vertices.size() == 0)
        begin
            $error("vertex transaction with no prediction waiting: x %0d y %0d",
                   $signed(vertex_bus.pos_x), $signed(vertex_bus.pos_y));
            error_count++;
        end
        else
        begin
            want = pending_vertices.pop_front();
            vertex_count++;
            if (vertex_bus.pos_x !== want.pos_x)
            begin
                $error("pos_x: expected %0d, actual %0d",
                       $signed(want.pos_x), $signed(vertex_bus.pos_x));
                error_count++;
            end
            if (vertex_bus.pos_y !== want.pos_y)
            begin
                $error("pos_y: expected %0d, actual %0d",
                       $signed(want.pos_y), $signed(vertex_bus.pos_y));
                error_count++;
            end
            if (vertex_bus.tex_u !== want.tex_u)
            begin
                $error("tex_u: expected %0d, actual %0d", want.tex_u, vertex_bus.tex_u);
                error_count++;
            end
            if (vertex_bus.tex_v !== want.tex_v)
            begin
                $error("tex_v: expected %0d, actual %0d", want.tex_v, vertex_bus.tex_v);
                error_count++;
            end
            if (vertex_bus.vertex_color !== want.vertex_color)
            begin
                $error("vertex_color: expected %08h, actual %08h",
                       want.vertex_color, vertex_bus.vertex_color);
                error_count++;
            end
            if (vertex_bus.last_vertex !== want.last_vertex)
            begin
                $error("last_vertex: expected %0b, actual %0b",
                       want.last_vertex, vertex_bus.last_vertex);
                error_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && vertex_bus.valid && vertex_bus.ready)
            check_vertex();
        if (stall_left > 0)
        begin
            stall_left--;
            vertex_bus.ready <= 1'b0;
        end
        else if (idle_enabled && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 4);
            vertex_bus.ready <= 1'b0;
        end
        else
        begin
            vertex_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        stim_row_t  row;
        logic [7:0] code;
        logic       first;
        int         string_left;

        rst_n                     <= 1'b0;
        cfg_wr_en                 <= 1'b0;
        cfg_index                 <= gqv_pkg::REG_ORIGIN_X;
        cfg_data                  <= '0;
        chars_bus.valid           <= 1'b0;
        chars_bus.char_code       <= '0;
        chars_bus.first_of_string <= 1'b0;

        model_origin_x = '0;
        model_origin_y = '0;
        model_size     = gqv_pkg::GLYPH_SIZE_RESET;
        model_color    = gqv_pkg::COLOR_RESET;
        cursor_x       = '0;
        cursor_y       = '0;

        directed_rows = '{
            typed_row(8'd65,  1'b0, 0, 0, 1, 4),
            typed_row(8'd255, 1'b0, 154, 0, 15, 15),
            char_row(gqv_pkg::NEWLINE_CODE, 1'b0),
            typed_row(8'd0,   1'b0, 0, 256, 0, 0),
            char_row(gqv_pkg::NEWLINE_CODE, 1'b1),
            typed_row(8'd1,   1'b1, 0, 0, 1, 0),
            reg_row(gqv_pkg::REG_ORIGIN_X,   32'h0000_7FFF),
            reg_row(gqv_pkg::REG_ORIGIN_Y,   32'h0000_7FFF),
            reg_row(gqv_pkg::REG_GLYPH_SIZE, 32'd4095),
            reg_row(gqv_pkg::REG_COLOR_RGBA, 32'h0000_0000),
            typed_row(8'd128, 1'b1, 32767, 32767, 0, 8),
            typed_row(8'd127, 1'b0, 32767, 32767, 15, 7),
            char_row(gqv_pkg::NEWLINE_CODE, 1'b0),
            char_row(8'd85, 1'b0),
            reg_row(gqv_pkg::REG_ORIGIN_X,   32'h0000_8000),
            reg_row(gqv_pkg::REG_ORIGIN_Y,   32'h0000_8000),
            reg_row(gqv_pkg::REG_GLYPH_SIZE, 32'd0),
            reg_row(gqv_pkg::REG_COLOR_RGBA, 32'h1234_5678),
            typed_row(8'd240, 1'b1, -32768, -32768, 0, 15),
            typed_row(8'd15,  1'b0, -32768, -32768, 15, 0),
            char_row(gqv_pkg::NEWLINE_CODE, 1'b0),
            typed_row(8'd170, 1'b0, -32768, -32768, 10, 10),
            reg_row(gqv_pkg::REG_GLYPH_SIZE, 32'd4095),
            typed_row(8'd200, 1'b1, -32768, -32768, 8, 12),
            char_row(gqv_pkg::NEWLINE_CODE, 1'b0),
            char_row(8'd11, 1'b0),
            char_row(8'd9, 1'b0),
            char_row(8'd32, 1'b1),
            reg_row(gqv_pkg::REG_GLYPH_SIZE, 32'd1),
            char_row(8'd66, 1'b1),
            char_row(8'd67, 1'b0),
            reg_row(gqv_pkg::REG_GLYPH_SIZE, 32'd255),
            char_row(8'd97, 1'b0),
            char_row(gqv_pkg::NEWLINE_CODE, 1'b0),
            char_row(8'd98, 1'b0),
            reg_row(gqv_pkg::REG_COLOR_RGBA, 32'hA5C3_0F96)
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
                write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
            else
                send_char(directed_rows[i]);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == RANDOM_PHASES - 1)
                idle_enabled = 1'b0;
            write_reg(gqv_pkg::REG_ORIGIN_X, random_position());
            write_reg(gqv_pkg::REG_ORIGIN_Y, random_position());
            if ($urandom_range(0, 3) == 0)
                write_reg(gqv_pkg::REG_GLYPH_SIZE, $urandom_range(0, 4095));
            else
                write_reg(gqv_pkg::REG_GLYPH_SIZE, $urandom_range(0, 400));
            write_reg(gqv_pkg::REG_COLOR_RGBA, $urandom);
            string_left = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase == 2 && n == ITEMS_PER_PHASE / 2)
                    wait_for_vertices(0);
                if (string_left == 0)
                begin
                    string_left = $urandom_range(1, 8);
                    first       = 1'b1;
                end
                else
                begin
                    first = ($urandom_range(0, 9) == 0);
                end
                string_left--;
                if ($urandom_range(0, 6) == 0)
                    code = gqv_pkg::NEWLINE_CODE;
                else
                    code = 8'($urandom_range(0, 255));
                row = char_row(code, first);
                send_char(row);
            end
        end

        wait_for_vertices(SETTLE_CYCLES);

        $display("Run covered %0d glyphs and %0d newlines over %0d register writes.",
                 glyph_count, newline_count, reg_writes);
        $display("%0d vertices compared, %0d mismatches.", vertex_count, error_count);
        if (error_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
